>>> rtl/i2cm_pkg.sv
package i2cm_pkg;

   // Register defaults and field widths
   localparam int ATTEMPT_W = 4;
   localparam logic [ATTEMPT_W-1:0] MAX_ATTEMPTS_RESET = 4'd4;

   // One input transaction
   typedef struct packed {
      logic [1:0] command;
      logic       sda_in;
      logic [6:0] address;
      logic       read_not_write;
      logic [7:0] byte_count;
      logic [7:0] write_byte;
   } req_type;

   // One result transaction
   typedef struct packed {
      logic       scl_low;
      logic       sda_low;
      logic       need_byte;
      logic [7:0] read_byte;
      logic       read_valid;
      logic       busy_res;
      logic       done_res;
      logic       status;
   } rsp_type;

endpackage

>>> rtl/i2cm_engine.sv
module i2cm_engine (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  i2cm_pkg::req_type               item,
   input  logic [i2cm_pkg::ATTEMPT_W-1:0]  max_attempts,
   output i2cm_pkg::rsp_type               result
);
   import i2cm_pkg::*;

   // Command codes
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_BEGIN = 2'd1;
   localparam logic [1:0] CMD_LOAD  = 2'd2;

   // Sequencer state codes
   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_START    = 4'd1;
   localparam logic [3:0] ST_ADDR     = 4'd2;
   localparam logic [3:0] ST_ADDR_ACK = 4'd3;
   localparam logic [3:0] ST_WAIT     = 4'd4;
   localparam logic [3:0] ST_DATA     = 4'd5;
   localparam logic [3:0] ST_DATA_ACK = 4'd6;
   localparam logic [3:0] ST_READ     = 4'd7;
   localparam logic [3:0] ST_READ_ACK = 4'd8;
   localparam logic [3:0] ST_STOP     = 4'd9;

   localparam logic [1:0] PH_SETUP  = 2'd0;
   localparam logic [1:0] PH_RISE   = 2'd1;
   localparam logic [1:0] PH_SAMPLE = 2'd2;
   localparam logic [1:0] PH_FALL   = 2'd3;

   logic [3:0]           state_ff, state_in;
   logic [1:0]           phase_ff, phase_in;
   logic [2:0]           bit_ff, bit_in;
   logic [7:0]           bytes_ff, bytes_in;
   logic [ATTEMPT_W-1:0] attempt_ff, attempt_in;
   logic [7:0]           shift_ff, shift_in;
   logic [6:0]           taddr_ff, taddr_in;
   logic                 dir_ff, dir_in;
   logic                 ack_ff, ack_in;
   logic                 scl_ff, scl_in;
   logic                 sda_ff, sda_in_drv;

   logic                 exhausted;
   logic [ATTEMPT_W:0]   limit;
   logic                 tx_bit;
   logic                 advance;
   logic                 rvalid;
   logic                 done;

   // Retry limit: a zero setting counts as one try
   always_comb begin
      limit     = (max_attempts == '0) ? {{ATTEMPT_W{1'b0}}, 1'b1} : {1'b0, max_attempts};
      exhausted = ({1'b0, attempt_ff} + {{ATTEMPT_W{1'b0}}, 1'b1}) >= limit;
   end

   // Bit on the wire for address and data shifts
   always_comb begin
      if (state_ff == ST_ADDR) begin
         tx_bit = (bit_ff == 3'd7) ? dir_ff : taddr_ff[3'd6 - bit_ff];
      end else begin
         tx_bit = shift_ff[3'd7 - bit_ff];
      end
   end

   // Advance the bus engine by one transaction
   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      bit_in     = bit_ff;
      bytes_in   = bytes_ff;
      attempt_in = attempt_ff;
      shift_in   = shift_ff;
      taddr_in   = taddr_ff;
      dir_in     = dir_ff;
      ack_in     = ack_ff;
      scl_in     = scl_ff;
      sda_in_drv = sda_ff;
      advance    = 1'b0;
      rvalid     = 1'b0;
      done       = 1'b0;

      if (item.command == CMD_TICK) begin
         advance = 1'b1;
         unique case (state_ff)
            ST_START: begin
               unique case (phase_ff)
                  PH_SETUP:  sda_in_drv = 1'b0;
                  PH_RISE:   scl_in = 1'b0;
                  PH_SAMPLE: sda_in_drv = 1'b1;
                  default: begin
                     scl_in   = 1'b1;
                     state_in = ST_ADDR;
                     bit_in   = 3'd0;
                  end
               endcase
            end
            ST_ADDR, ST_DATA: begin
               unique case (phase_ff)
                  PH_SETUP: begin
                     scl_in     = 1'b1;
                     sda_in_drv = ~tx_bit;
                  end
                  PH_RISE:   scl_in = 1'b0;
                  PH_SAMPLE: ;
                  default: begin
                     scl_in = 1'b1;
                     if (bit_ff == 3'd7) begin
                        state_in = (state_ff == ST_ADDR) ? ST_ADDR_ACK : ST_DATA_ACK;
                        bit_in   = 3'd0;
                     end else begin
                        bit_in = bit_ff + 3'd1;
                     end
                  end
               endcase
            end
            ST_ADDR_ACK: begin
               unique case (phase_ff)
                  PH_SETUP: begin
                     scl_in     = 1'b1;
                     sda_in_drv = 1'b0;
                  end
                  PH_RISE:   scl_in = 1'b0;
                  PH_SAMPLE: ack_in = item.sda_in;
                  default: begin
                     scl_in = 1'b1;
                     bit_in = 3'd0;
                     if (!ack_ff || exhausted) begin
                        attempt_in = '0;
                        shift_in   = 8'd0;
                        state_in   = dir_ff ? ST_READ : ST_WAIT;
                     end else begin
                        attempt_in = attempt_ff + 1'b1;
                        state_in   = ST_ADDR;
                     end
                  end
               endcase
            end
            ST_DATA_ACK: begin
               unique case (phase_ff)
                  PH_SETUP:  sda_in_drv = 1'b0;
                  PH_RISE:   scl_in = 1'b0;
                  PH_SAMPLE: ack_in = item.sda_in;
                  default: begin
                     sda_in_drv = 1'b1;
                     scl_in     = 1'b1;
                     bit_in     = 3'd0;
                     if (!ack_ff) begin
                        attempt_in = '0;
                        if (bytes_ff <= 8'd1) begin
                           state_in = ST_STOP;
                        end else begin
                           bytes_in = bytes_ff - 8'd1;
                           state_in = ST_WAIT;
                        end
                     end else if (!exhausted) begin
                        attempt_in = attempt_ff + 1'b1;
                        state_in   = ST_DATA;
                     end else begin
                        attempt_in = '0;
                        // Final byte refused on every try: end without a stop
                        if (bytes_ff <= 8'd1) begin
                           bytes_in = 8'd0;
                           state_in = ST_IDLE;
                           done     = 1'b1;
                        end else begin
                           bytes_in = bytes_ff - 8'd1;
                           state_in = ST_WAIT;
                        end
                     end
                  end
               endcase
            end
            ST_READ: begin
               unique case (phase_ff)
                  PH_SETUP: begin
                     scl_in     = 1'b1;
                     sda_in_drv = 1'b0;
                  end
                  PH_RISE:   scl_in = 1'b0;
                  PH_SAMPLE: shift_in = {shift_ff[6:0], item.sda_in};
                  default: begin
                     scl_in = 1'b1;
                     if (bit_ff == 3'd7) begin
                        rvalid   = 1'b1;
                        bit_in   = 3'd0;
                        state_in = ST_READ_ACK;
                     end else begin
                        bit_in = bit_ff + 3'd1;
                     end
                  end
               endcase
            end
            ST_READ_ACK: begin
               unique case (phase_ff)
                  PH_SETUP:  sda_in_drv = (bytes_ff > 8'd1);
                  PH_RISE:   scl_in = 1'b0;
                  PH_SAMPLE: ;
                  default: begin
                     scl_in = 1'b1;
                     if (bytes_ff <= 8'd1) begin
                        sda_in_drv = 1'b1;
                        state_in   = ST_STOP;
                     end else begin
                        bytes_in = bytes_ff - 8'd1;
                        shift_in = 8'd0;
                        bit_in   = 3'd0;
                        state_in = ST_READ;
                     end
                  end
               endcase
            end
            ST_STOP: begin
               unique case (phase_ff)
                  PH_SETUP:  sda_in_drv = 1'b1;
                  PH_RISE:   scl_in = 1'b0;
                  PH_SAMPLE: sda_in_drv = 1'b0;
                  default: begin
                     bytes_in = 8'd0;
                     state_in = ST_IDLE;
                     done     = 1'b1;
                  end
               endcase
            end
            default: advance = 1'b0;
         endcase
         if (advance) begin
            phase_in = phase_ff + 2'd1;
         end
      end else if (item.command == CMD_BEGIN) begin
         if (state_ff == ST_IDLE) begin
            taddr_in   = item.address;
            dir_in     = item.read_not_write;
            bytes_in   = (item.byte_count == 8'd0) ? 8'd1 : item.byte_count;
            attempt_in = '0;
            bit_in     = 3'd0;
            phase_in   = 2'd0;
            shift_in   = 8'd0;
            ack_in     = 1'b0;
            state_in   = ST_START;
         end
      end else if (item.command == CMD_LOAD) begin
         if (state_ff == ST_WAIT) begin
            shift_in   = item.write_byte;
            attempt_in = '0;
            bit_in     = 3'd0;
            phase_in   = 2'd0;
            state_in   = ST_DATA;
         end
      end
   end

   // Build the result from the updated state
   always_comb begin
      result.scl_low    = scl_in;
      result.sda_low    = sda_in_drv;
      result.need_byte  = (state_in == ST_WAIT);
      result.read_byte  = rvalid ? shift_in : 8'd0;
      result.read_valid = rvalid;
      result.busy_res   = (state_in != ST_IDLE);
      result.done_res   = done;
      result.status     = done ? ack_in : 1'b0;
   end

   // Hold state between transactions
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         phase_ff   <= 2'd0;
         bit_ff     <= 3'd0;
         bytes_ff   <= 8'd0;
         attempt_ff <= '0;
         shift_ff   <= 8'd0;
         taddr_ff   <= 7'd0;
         dir_ff     <= 1'b0;
         ack_ff     <= 1'b0;
         scl_ff     <= 1'b0;
         sda_ff     <= 1'b0;
      end else if (step) begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         bit_ff     <= bit_in;
         bytes_ff   <= bytes_in;
         attempt_ff <= attempt_in;
         shift_ff   <= shift_in;
         taddr_ff   <= taddr_in;
         dir_ff     <= dir_in;
         ack_ff     <= ack_in;
         scl_ff     <= scl_in;
         sda_ff     <= sda_in_drv;
      end
   end

endmodule

>>> rtl/i2c_master_with_retry_top.sv
// Open-drain I2C master with per-byte retry, driven one quarter-bit phase per
// transaction.
// Request channel (req_valid / req_stall / req_item): a begin command latches
// address, direction and byte count; tick commands step the bus one phase and
// carry the sampled SDA level; load commands hand over the next write byte.
// Response channel (rsp_valid / rsp_stall / rsp_item): exactly one response
// per request, in order, with the line drives, need_byte, a received byte,
// busy, done and the final ACK status.
// csr_wr_en / csr_wr_data set max_attempts; write it only while idle.
// A request lands in the input register; the engine then updates its state
// and fills the response register once that register is free.
// Throughput is one request per clock while rsp_stall holds no response back.
// While rsp_stall is high with a response pending, one more request is
// buffered and then req_stall rises; nothing is dropped.
// Reset empties both registers, idles the engine, releases both lines and
// sets max_attempts to 4.
module i2c_master_with_retry_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  i2cm_pkg::req_type               req_item,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output i2cm_pkg::rsp_type               rsp_item,
   input  logic                            csr_wr_en,
   input  logic [i2cm_pkg::ATTEMPT_W-1:0]  csr_wr_data
);
   import i2cm_pkg::*;

   logic                 in_valid_ff, in_valid_in;
   req_type              in_item_ff;
   logic                 out_valid_ff, out_valid_in;
   rsp_type              out_item_ff;
   rsp_type              step_result;
   logic [ATTEMPT_W-1:0] max_att_ff;
   logic                 out_free;
   logic                 step;
   logic                 accept;

   // Handshake between the input and response registers
   always_comb begin
      out_free     = !out_valid_ff || !rsp_stall;
      step         = in_valid_ff && out_free;
      req_stall    = in_valid_ff && !out_free;
      accept       = req_valid && !req_stall;
      in_valid_in  = accept || (in_valid_ff && !step);
      out_valid_in = step || (out_valid_ff && rsp_stall);
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   i2cm_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .item         (in_item_ff),
      .max_attempts (max_att_ff),
      .result       (step_result)
   );

   // Track valid flags and the retry setting
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         max_att_ff   <= MAX_ATTEMPTS_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            max_att_ff <= csr_wr_data;
         end
      end
   end

   // Capture payloads
   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_item;
      end
      if (step) begin
         out_item_ff <= step_result;
      end
   end

   // A finished transaction never reports busy
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.done_res |-> !rsp_item.busy_res)
      else $error("done reported while still busy");

   // A received byte arrives only during a transaction
   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.read_valid |-> rsp_item.busy_res && !rsp_item.need_byte)
      else $error("read byte outside an active read");

   // Back-pressure only when the response side is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a blocked response");

   // A buffered request always produces a response on the next edge once free
   a_step_out: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid)
      else $error("stepped request produced no response");

endmodule
